/* sv/uvsvg_pkg.sv */
package uvsvg_pkg;

  localparam int DIV_STEPS = 25;
  localparam int SIN_ITERS = 5;
  localparam int LAT_SIN   = 2 + 3 * SIN_ITERS + 1;
  localparam int LAT_TOTAL = DIV_STEPS + LAT_SIN + 4;

  localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [1:0] REG_STACK_COUNT = 2'd0;
  localparam logic [1:0] REG_SLICE_COUNT = 2'd1;
  localparam logic [1:0] REG_RADIUS      = 2'd2;

  localparam logic [7:0]  STACK_COUNT_RST = 8'd32;
  localparam logic [7:0]  SLICE_COUNT_RST = 8'd64;
  localparam logic [15:0] RADIUS_RST      = 16'd4096;

  // series divisors, innermost first
  function automatic logic [6:0] div_k(input int idx);
    case (idx)
      0:       div_k = 7'd110;
      1:       div_k = 7'd72;
      2:       div_k = 7'd42;
      3:       div_k = 7'd20;
      default: div_k = 7'd6;
    endcase
  endfunction

  // floor(2^sh / k), one short at most after the shift
  function automatic logic [31:0] recip_m(input int idx);
    case (idx)
      0:       recip_m = 32'd2498890063;
      1:       recip_m = 32'd3817748707;
      2:       recip_m = 32'd3272356035;
      3:       recip_m = 32'd3435973836;
      default: recip_m = 32'd2863311530;
    endcase
  endfunction

  function automatic int recip_sh(input int idx);
    case (idx)
      0:       recip_sh = 38;
      1:       recip_sh = 38;
      2:       recip_sh = 37;
      3:       recip_sh = 36;
      default: recip_sh = 34;
    endcase
  endfunction

endpackage

/* sv/uvsvg_div.sv */
module uvsvg_div import uvsvg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [8:0]  rem_i,
  input  logic [24:0] num_i,
  input  logic [8:0]  den_i,
  output logic [24:0] quo_o
);

  logic [8:0]  r_q [DIV_STEPS];
  logic [8:0]  d_q [DIV_STEPS];
  logic [24:0] l_q [DIV_STEPS];
  logic [24:0] q_q [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [8:0]  r_in, d_in, r_d;
    logic [24:0] l_in, q_in, q_d;
    logic [9:0]  rs;
    logic        ge;

    if (k == 0) begin : g_first
      assign r_in = rem_i;
      assign d_in = den_i;
      assign l_in = num_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = r_q[k-1];
      assign d_in = d_q[k-1];
      assign l_in = l_q[k-1];
      assign q_in = q_q[k-1];
    end

    assign rs = {r_in, l_in[DIV_STEPS-1-k]};
    assign ge = (rs >= {1'b0, d_in});

    always_comb begin
      r_d = ge ? 9'(rs - {1'b0, d_in}) : rs[8:0];
      q_d = q_in;
      q_d[DIV_STEPS-1-k] = ge;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k] <= r_d;
        d_q[k] <= d_in;
        l_q[k] <= l_in;
        q_q[k] <= q_d;
      end
    end
  end

  assign quo_o = q_q[DIV_STEPS-1];

endmodule

/* sv/uvsvg_qsin.sv */
module uvsvg_qsin import uvsvg_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [22:0] f_i,
  output logic [30:0] s_o
);

  logic [53:0] fx;
  logic [61:0] xx;
  logic [30:0] x0_q, x1_q;
  logic [31:0] x2_1_q;

  assign fx = 54'(f_i) * 54'(HALF_PI_Q30);
  assign xx = 62'(x0_q) * 62'(x0_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q   <= fx[52:22];
      x1_q   <= x0_q;
      x2_1_q <= xx[61:30];
    end
  end

  // Horner form of the odd series, three stages per term
  logic [31:0] va_q  [SIN_ITERS];
  logic [30:0] xa_q  [SIN_ITERS];
  logic [31:0] x2a_q [SIN_ITERS];
  logic [31:0] q0_q  [SIN_ITERS];
  logic [31:0] vb_q  [SIN_ITERS];
  logic [30:0] xb_q  [SIN_ITERS];
  logic [31:0] x2b_q [SIN_ITERS];
  logic [30:0] h_q   [SIN_ITERS];
  logic [30:0] xc_q  [SIN_ITERS];
  logic [31:0] x2c_q [SIN_ITERS];

  for (genvar g = 0; g < SIN_ITERS; g++) begin : g_term
    localparam logic [31:0] M  = recip_m(g);
    localparam int          SH = recip_sh(g);
    localparam logic [31:0] K  = 32'(div_k(g));

    logic [30:0] h_in, x_in;
    logic [31:0] x2_in, qk, rr, qc;
    logic [62:0] pa;
    logic [63:0] pb;

    if (g == 0) begin : g_first
      assign h_in  = Q30_ONE[30:0];
      assign x_in  = x1_q;
      assign x2_in = x2_1_q;
    end else begin : g_next
      assign h_in  = h_q[g-1];
      assign x_in  = xc_q[g-1];
      assign x2_in = x2c_q[g-1];
    end

    assign pa = 63'(x2_in) * 63'(h_in);
    assign pb = 64'(va_q[g]) * 64'(M);
    assign qk = 32'(q0_q[g] * K);
    assign rr = vb_q[g] - qk;
    assign qc = q0_q[g] + ((rr >= K) ? 32'd1 : 32'd0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        va_q[g]  <= pa[61:30];
        xa_q[g]  <= x_in;
        x2a_q[g] <= x2_in;
        q0_q[g]  <= 32'(pb >> SH);
        vb_q[g]  <= va_q[g];
        xb_q[g]  <= xa_q[g];
        x2b_q[g] <= x2a_q[g];
        h_q[g]   <= 31'(Q30_ONE - qc);
        xc_q[g]  <= xb_q[g];
        x2c_q[g] <= x2b_q[g];
      end
    end
  end

  logic [61:0] pf;
  logic [30:0] s_q;

  assign pf = 62'(xc_q[SIN_ITERS-1]) * 62'(h_q[SIN_ITERS-1]);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= (pf[61:30] > Q30_ONE) ? Q30_ONE[30:0] : pf[60:30];
    end
  end

  assign s_o = s_q;

endmodule

/* sv/uv_sphere_vertex_generator.sv */
// Each accepted input word passes 25 divider steps, 18 sine stages and 4 product/output stages.
// Throughput: one word per cycle unless the master side stalls.
// A stall on the master side freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits and loads stack_count 32, slice_count 64, radius 1.0.
// Configuration is taken on any cycle with cfg_we_i high; index 3 is ignored.
module uv_sphere_vertex_generator import uvsvg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // stack_index, slice_index
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata,   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);

  typedef struct packed {
    logic [1:0]  q_phi;
    logic [1:0]  q_th;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
  } side_t;

  typedef struct packed {
    logic nx;
    logic ny;
    logic nz;
  } sign_t;

  logic [7:0]  stack_count_q, slice_count_q;
  logic [15:0] radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_count_q <= STACK_COUNT_RST;
      slice_count_q <= SLICE_COUNT_RST;
      radius_q      <= RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STACK_COUNT: stack_count_q <= cfg_data_i[7:0];
        REG_SLICE_COUNT: slice_count_q <= cfg_data_i[7:0];
        REG_RADIUS:      radius_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                 en;
  logic [LAT_TOTAL-1:0] vld_q;

  assign en            = !vld_q[LAT_TOTAL-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT_TOTAL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT_TOTAL-2:0], s_axis_tvalid};
    end
  end

  // saturate indices, zero count reads as one
  logic [7:0] st, sl, i_sat, j_sat;

  assign st    = (stack_count_q == 8'd0) ? 8'd1 : stack_count_q;
  assign sl    = (slice_count_q == 8'd0) ? 8'd1 : slice_count_q;
  assign i_sat = (s_axis_tdata[7:0] > st) ? st : s_axis_tdata[7:0];
  assign j_sat = (s_axis_tdata[15:8] > sl) ? sl : s_axis_tdata[15:8];

  logic [24:0] quo_phi, quo_th, quo_u, quo_v;

  uvsvg_div u_div_phi (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i ({2'b00, i_sat[7:1]}),
    .num_i ({i_sat[0], 16'd0, st}),
    .den_i ({st, 1'b0}),
    .quo_o (quo_phi)
  );

  uvsvg_div u_div_th (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i ({2'b00, j_sat[7:1]}),
    .num_i ({j_sat[0], 17'd0, sl[7:1]}),
    .den_i ({1'b0, sl}),
    .quo_o (quo_th)
  );

  uvsvg_div u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (9'd0),
    .num_i ({1'b0, j_sat, 9'd0, sl[7:1]}),
    .den_i ({1'b0, sl}),
    .quo_o (quo_u)
  );

  uvsvg_div u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (9'd0),
    .num_i ({1'b0, i_sat, 9'd0, st[7:1]}),
    .den_i ({1'b0, st}),
    .quo_o (quo_v)
  );

  // turn fraction: quadrant in bits 23..22, full turn wraps
  logic [22:0] g_phi, g_th;
  logic [30:0] sa_phi, sb_phi, sa_th, sb_th;

  assign g_phi = 23'(23'h40_0000 - {1'b0, quo_phi[21:0]});
  assign g_th  = 23'(23'h40_0000 - {1'b0, quo_th[21:0]});

  uvsvg_qsin u_sin_phi_f (
    .clk_i (clk_i), .en_i (en), .f_i ({1'b0, quo_phi[21:0]}), .s_o (sa_phi)
  );
  uvsvg_qsin u_sin_phi_g (
    .clk_i (clk_i), .en_i (en), .f_i (g_phi), .s_o (sb_phi)
  );
  uvsvg_qsin u_sin_th_f (
    .clk_i (clk_i), .en_i (en), .f_i ({1'b0, quo_th[21:0]}), .s_o (sa_th)
  );
  uvsvg_qsin u_sin_th_g (
    .clk_i (clk_i), .en_i (en), .f_i (g_th), .s_o (sb_th)
  );

  side_t sb_q [LAT_SIN];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= '{q_phi: quo_phi[23:22], q_th: quo_th[23:22],
                   tex_u: quo_u[16:0], tex_v: quo_v[16:0]};
      for (int n = 1; n < LAT_SIN; n++) sb_q[n] <= sb_q[n-1];
    end
  end

  side_t       sd;
  logic [30:0] sp, cp, stm, ctm;
  sign_t       sg;

  always_comb begin
    sd    = sb_q[LAT_SIN-1];
    sp    = sd.q_phi[0] ? sb_phi : sa_phi;
    cp    = sd.q_phi[0] ? sa_phi : sb_phi;
    stm   = sd.q_th[0]  ? sb_th  : sa_th;
    ctm   = sd.q_th[0]  ? sa_th  : sb_th;
    sg.nx = sd.q_phi[1] ^ (sd.q_th[1] ^ sd.q_th[0]);
    sg.ny = sd.q_phi[1] ^ sd.q_phi[0];
    sg.nz = sd.q_phi[1] ^ sd.q_th[1];
  end

  // P1: direction products
  logic [61:0] prx_q, prz_q;
  logic [30:0] cp1_q;
  sign_t       sg1_q, sg2_q, sg3_q;
  logic [16:0] u1_q, v1_q, u2_q, v2_q, u3_q, v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      prx_q <= 62'(sp) * 62'(ctm);
      prz_q <= 62'(sp) * 62'(stm);
      cp1_q <= cp;
      sg1_q <= sg;
      u1_q  <= sd.tex_u;
      v1_q  <= sd.tex_v;
    end
  end

  // P2: rounding
  logic [61:0] rx30, rz30, rx46, rz46;
  logic [31:0] ry16;
  logic [14:0] mx, my, mz;
  logic [30:0] px2_q, py2_q, pz2_q;
  logic [14:0] nx2_q, ny2_q, nz2_q, nx3_q, ny3_q, nz3_q;

  assign rx30 = prx_q + 62'(1) * 62'h2000_0000;
  assign rz30 = prz_q + 62'h2000_0000;
  assign rx46 = prx_q + 62'h2000_0000_0000;
  assign rz46 = prz_q + 62'h2000_0000_0000;
  assign ry16 = 32'(cp1_q) + 32'h8000;
  assign mx   = (rx46[60:46] > 15'd16384) ? 15'd16384 : rx46[60:46];
  assign my   = (ry16[30:16] > 15'd16384) ? 15'd16384 : ry16[30:16];
  assign mz   = (rz46[60:46] > 15'd16384) ? 15'd16384 : rz46[60:46];

  always_ff @(posedge clk_i) begin
    if (en) begin
      px2_q <= rx30[60:30];
      py2_q <= cp1_q;
      pz2_q <= rz30[60:30];
      nx2_q <= mx;
      ny2_q <= my;
      nz2_q <= mz;
      sg2_q <= sg1_q;
      u2_q  <= u1_q;
      v2_q  <= v1_q;
    end
  end

  // P3: radius scaling
  logic [46:0] rpx_q, rpy_q, rpz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rpx_q <= 47'(radius_q) * 47'(px2_q);
      rpy_q <= 47'(radius_q) * 47'(py2_q);
      rpz_q <= 47'(radius_q) * 47'(pz2_q);
      nx3_q <= nx2_q;
      ny3_q <= ny2_q;
      nz3_q <= nz2_q;
      sg3_q <= sg2_q;
      u3_q  <= u2_q;
      v3_q  <= v2_q;
    end
  end

  // output register
  logic [47:0] sx, sy, sz;
  logic [17:0] pos_x_q, pos_y_q, pos_z_q;
  logic [15:0] norm_x_q, norm_y_q, norm_z_q;
  logic [16:0] tex_u_q, tex_v_q;

  assign sx = 48'(rpx_q) + 48'h2000_0000;
  assign sy = 48'(rpy_q) + 48'h2000_0000;
  assign sz = 48'(rpz_q) + 48'h2000_0000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_q  <= sg3_q.nx ? 18'(18'd0 - {1'b0, sx[46:30]}) : {1'b0, sx[46:30]};
      pos_y_q  <= sg3_q.ny ? 18'(18'd0 - {1'b0, sy[46:30]}) : {1'b0, sy[46:30]};
      pos_z_q  <= sg3_q.nz ? 18'(18'd0 - {1'b0, sz[46:30]}) : {1'b0, sz[46:30]};
      norm_x_q <= sg3_q.nx ? 16'(16'd0 - {1'b0, nx3_q}) : {1'b0, nx3_q};
      norm_y_q <= sg3_q.ny ? 16'(16'd0 - {1'b0, ny3_q}) : {1'b0, ny3_q};
      norm_z_q <= sg3_q.nz ? 16'(16'd0 - {1'b0, nz3_q}) : {1'b0, nz3_q};
      tex_u_q  <= u3_q;
      tex_v_q  <= v3_q;
    end
  end

  assign m_axis_tdata = {tex_v_q, tex_u_q, norm_z_q, norm_y_q, norm_x_q,
                         pos_z_q, pos_y_q, pos_x_q};

  a_accept_loads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted word not marked valid");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid pipeline moved during stall");

  a_tex_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (tex_u_q <= 17'd65536) && (tex_v_q <= 17'd65536))
    else $error("texture coordinate above one");

  a_norm_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(norm_y_q) <= 16'sd16384) && ($signed(norm_y_q) >= -16'sd16384))
    else $error("normal component out of range");

endmodule

/* tb/uv_sphere_vertex_generator_tb.sv */
module uv_sphere_vertex_generator_tb;
  import uvsvg_pkg::*;

  typedef struct packed {
    logic [16:0] tex_v;
    logic [16:0] tex_u;
    logic [15:0] norm_z;
    logic [15:0] norm_y;
    logic [15:0] norm_x;
    logic [17:0] pos_z;
    logic [17:0] pos_y;
    logic [17:0] pos_x;
  } vertex_t;

  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam logic [63:0] QTURN   = 64'd4194304;
  localparam int LIMIT = 2000000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = '0;
  logic [15:0]  cfg_data_i = '0;

  logic [7:0]  n_stacks;
  logic [7:0]  n_slices;
  logic [15:0] rad_q12;

  logic [15:0] pending_words[$];
  vertex_t     expected_vertices[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  uv_sphere_vertex_generator i_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #10 clk_i = ~clk_i;

  function automatic logic [63:0] qsin(input logic [63:0] f);
    logic [63:0] x, x2, h, s;
    int k;
    x  = (f * 64'd1686629713) >> 22;
    x2 = (x * x) >> 30;
    h  = ONE_Q30;
    for (k = 0; k < 5; k++) begin
      h = ONE_Q30 - ((x2 * h) >> 30) / 64'(div_k(k));
    end
    s = (x * h) >> 30;
    return (s > ONE_Q30) ? ONE_Q30 : s;
  endfunction

  function automatic void turn_trig(input logic [63:0] t, output logic [63:0] sm,
                                    output bit sn, output logic [63:0] cm, output bit cn);
    logic [63:0] f, a, b;
    f = t & (QTURN - 1);
    a = qsin(f);
    b = qsin(QTURN - f);
    case ((t >> 22) & 3)
      0: begin sm = a; sn = 0; cm = b; cn = 0; end
      1: begin sm = b; sn = 0; cm = a; cn = 1; end
      2: begin sm = a; sn = 1; cm = b; cn = 1; end
      default: begin sm = b; sn = 1; cm = a; cn = 0; end
    endcase
  endfunction

  function automatic logic [63:0] signed_enc(input logic [63:0] m, input bit neg);
    return neg ? (64'd0 - m) : m;
  endfunction

  function automatic logic [63:0] to_pos(input logic [63:0] p);
    return (64'(rad_q12) * p + (64'd1 << 29)) >> 30;
  endfunction

  function automatic logic [63:0] cap_norm(input logic [63:0] m);
    return (m > 64'd16384) ? 64'd16384 : m;
  endfunction

  function automatic vertex_t vertex_of(input logic [15:0] w);
    logic [63:0] st, sl, i, j, tphi, tth, sp, cp, stm, ctm, px, pz;
    bit spn, cpn, stn, ctn, nx, nz;
    vertex_t v;
    st = (n_stacks == 0) ? 1 : 64'(n_stacks);
    sl = (n_slices == 0) ? 1 : 64'(n_slices);
    i = 64'(w[7:0]);
    j = 64'(w[15:8]);
    if (i > st) i = st;
    if (j > sl) j = sl;
    tphi = ((i << 24) + st) / (2 * st);
    tth  = ((j << 24) + sl / 2) / sl;
    turn_trig(tphi, sp, spn, cp, cpn);
    turn_trig(tth, stm, stn, ctm, ctn);
    nx = spn != ctn;
    nz = spn != stn;
    px = (sp * ctm + (64'd1 << 29)) >> 30;
    pz = (sp * stm + (64'd1 << 29)) >> 30;
    v.pos_x  = 18'(signed_enc(to_pos(px), nx));
    v.pos_y  = 18'(signed_enc(to_pos(cp), cpn));
    v.pos_z  = 18'(signed_enc(to_pos(pz), nz));
    v.norm_x = 16'(signed_enc(cap_norm((sp * ctm + (64'd1 << 45)) >> 46), nx));
    v.norm_y = 16'(signed_enc(cap_norm((cp + (64'd1 << 15)) >> 16), cpn));
    v.norm_z = 16'(signed_enc(cap_norm((sp * stm + (64'd1 << 45)) >> 46), nz));
    v.tex_u  = 17'(((j << 16) + sl / 2) / sl);
    v.tex_v  = 17'(((i << 16) + st / 2) / st);
    return v;
  endfunction

  // driver
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("uv_sphere_vertex_generator_tb NOT OK");
      $finish;
    end
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tdata <= pending_words[0];
          expected_vertices = {expected_vertices, vertex_of(pending_words[0])};
          void'(pending_words.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    vertex_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = vertex_t'(m_axis_tdata);
      if (expected_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = expected_vertices.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %h got %h", want, got);
        end
      end
    end
  end

  task automatic queue_word(input logic [15:0] w);
    pending_words = {pending_words, w};
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_STACK_COUNT: n_stacks = val[7:0];
      REG_SLICE_COUNT: n_slices = val[7:0];
      REG_RADIUS:      rad_q12 = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    wait (pending_words.size() == 0 && !s_axis_tvalid && expected_vertices.size() == 0);
    repeat (LAT_TOTAL + 10) @(posedge clk_i);
  endtask

  task automatic set_shape(input logic [7:0] st, input logic [7:0] sl, input logic [15:0] r);
    write_reg(REG_STACK_COUNT, {8'd0, st});
    write_reg(REG_SLICE_COUNT, {8'd0, sl});
    write_reg(REG_RADIUS, r);
  endtask

  // mostly in-range indices, some beyond the counts
  task automatic add_random(input int n);
    logic [7:0] i, j;
    repeat (n) begin
      i = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(n_stacks));
      j = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(n_slices));
      queue_word({j, i});
    end
  endtask

  initial begin
    n_stacks = STACK_COUNT_RST;
    n_slices = SLICE_COUNT_RST;
    rad_q12  = RADIUS_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // defaults, poles, full turn, saturation
    queue_word({8'd0, 8'd0});
    queue_word({8'd64, 8'd32});
    queue_word({8'd16, 8'd16});
    queue_word({8'd255, 8'd255});
    queue_word({8'd48, 8'd8});
    queue_word({8'd170, 8'd85});
    drain();
    set_shape(8'd0, 8'd0, 16'd0);
    queue_word({8'd0, 8'd0});
    queue_word({8'd1, 8'd1});
    queue_word({8'd255, 8'd255});
    drain();
    set_shape(8'd255, 8'd255, 16'hFFFF);
    queue_word({8'd0, 8'd0});
    queue_word({8'd255, 8'd255});
    queue_word({8'd127, 8'd128});
    queue_word({8'd64, 8'd63});
    queue_word({8'd191, 8'd191});
    queue_word({8'd85, 8'd170});
    drain();
    write_reg(REG_UNUSED, 16'h1234);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      case (ph)
        0: set_shape(8'd1, 8'd1, 16'd4096);
        1: set_shape(8'd255, 8'd255, 16'hFFFF);
        2: set_shape(8'd0, 8'd0, 16'd0);
        default: set_shape(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                           16'($urandom));
      endcase
      add_random(230);
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    if (mismatches == 0) begin
      $display("uv_sphere_vertex_generator_tb OK");
    end else begin
      $display("uv_sphere_vertex_generator_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
sv/uvsvg_pkg.sv
sv/uvsvg_div.sv
sv/uvsvg_qsin.sv
sv/uv_sphere_vertex_generator.sv
tb/uv_sphere_vertex_generator_tb.sv
